### rtl/core/bhpq_pkg.sv
package bhpq_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int TAG_WIDTH_DEF = 16;

    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 11;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_PUSH_START,
        CMD_POP_START,
        CMD_UP_READ,
        CMD_UP_STEP,
        CMD_DN_READ_L,
        CMD_DN_READ_R,
        CMD_DN_STEP,
        CMD_WRITE_HOLD
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic up_move;
        logic dn_has_left;
        logic dn_has_right;
        logic dn_move;
        logic last_zero;
    } stat_t;

endpackage

### rtl/core/binary_heap_priority_queue.sv
// Binary heap priority queue over one single-port-write memory of DEPTH entries. Each request
// is a push (s_tuser 0) or a pop (s_tuser 1) and gives one result. A push climbs level by
// level and a pop sinks level by level, each step waiting on the memory's one registered read
// port; a refused push or an empty pop goes straight to the result. One request is in flight
// at a time and the next is taken in the cycle after the result is accepted. config_data bit 0
// picks min (0) or max (1) order on the unsigned key; the user must see that it is written only
// while no request is in progress, as the block itself does not enforce it.
module binary_heap_priority_queue #(
    parameter int DEPTH     = bhpq_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEF,
    parameter int TAG_WIDTH = bhpq_pkg::TAG_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic config_valid,
    output logic config_ready,
    input  logic config_data,
    input  logic s_tvalid,
    output logic s_tready,
    // item_key, item_tag
    input  logic [((KEY_WIDTH+TAG_WIDTH+7)/8)*8-1:0] s_tdata,
    // action
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // top_key, top_tag, status, entry_count, is_empty
    output logic [((KEY_WIDTH+TAG_WIDTH+bhpq_pkg::STATUS_W+bhpq_pkg::COUNT_OUT_W+1+7)/8)*8-1:0]
                 m_tdata
);
    localparam int CW = $clog2(DEPTH+1);

    logic order_reg;
    bhpq_pkg::cmd_t  cmd;
    bhpq_pkg::stat_t stat;
    logic [KEY_WIDTH-1:0] top_key;
    logic [TAG_WIDTH-1:0] top_tag;
    logic [CW-1:0] count;
    logic [1:0] status;
    logic clr_top;
    logic [bhpq_pkg::COUNT_OUT_W-1:0] count_out;

    assign config_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) order_reg <= 1'b0;
        else if (config_valid) order_reg <= config_data;
    end

    bhpq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_pop(s_tuser),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_status(status),
        .clr_top(clr_top), .cmd(cmd), .stat(stat)
    );

    bhpq_datapath #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH), .TAG_WIDTH(TAG_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .order_mode(order_reg), .cmd(cmd),
        .in_key(s_tdata[KEY_WIDTH-1:0]), .in_tag(s_tdata[KEY_WIDTH+TAG_WIDTH-1:KEY_WIDTH]),
        .stat(stat), .top_key(top_key), .top_tag(top_tag), .count(count)
    );

    assign count_out = bhpq_pkg::COUNT_OUT_W'(count);
    assign m_tdata = ($bits(m_tdata))'({(count == '0), count_out, status,
                                        clr_top ? '0 : top_tag, clr_top ? '0 : top_key});
endmodule

### rtl/core/bhpq_datapath.sv
module bhpq_datapath #(
    parameter int DEPTH     = bhpq_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEF,
    parameter int TAG_WIDTH = bhpq_pkg::TAG_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 order_mode,
    input  bhpq_pkg::cmd_t       cmd,
    input  logic [KEY_WIDTH-1:0] in_key,
    input  logic [TAG_WIDTH-1:0] in_tag,
    output bhpq_pkg::stat_t      stat,
    output logic [KEY_WIDTH-1:0] top_key,
    output logic [TAG_WIDTH-1:0] top_tag,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int EW = KEY_WIDTH + TAG_WIDTH;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic [EW-1:0] left_reg, left_next;
    logic [EW-1:0] hold_reg, hold_next;
    logic [KEY_WIDTH-1:0] top_key_reg, top_key_next;
    logic [TAG_WIDTH-1:0] top_tag_reg, top_tag_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW:0]   pos_reg, pos_next;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] wr_data;
    logic          wr_en;

    logic [CW:0] parent, left_idx, right_idx;
    logic [KEY_WIDTH-1:0] hold_key, rd_key, left_key, pick_key;
    logic has_right;
    logic pick_right;

    function automatic logic beats(input logic mode, input logic [KEY_WIDTH-1:0] a,
                                   input logic [KEY_WIDTH-1:0] b);
        beats = mode ? (a > b) : (a < b);
    endfunction

    assign parent    = (pos_reg - 1'b1) >> 1;
    assign left_idx  = {pos_reg[CW-1:0], 1'b1};
    assign right_idx = left_idx + 1'b1;
    assign hold_key  = hold_reg[EW-1:TAG_WIDTH];
    assign rd_key    = rd_data_reg[EW-1:TAG_WIDTH];
    assign left_key  = left_reg[EW-1:TAG_WIDTH];
    assign has_right = (right_idx < {1'b0, count_reg});
    // right data sits in rd_data_reg after the second read
    assign pick_right = has_right && beats(order_mode, rd_key, left_key);
    assign pick_key   = pick_right ? rd_key : left_key;

    always_comb begin
        stat.full         = (count_reg == CW'(DEPTH));
        stat.empty        = (count_reg == '0);
        stat.at_root      = (pos_reg == '0);
        stat.up_move      = beats(order_mode, hold_key, rd_key);
        stat.dn_has_left  = (left_idx < {1'b0, count_reg});
        stat.dn_has_right = has_right;
        stat.dn_move      = beats(order_mode, pick_key, hold_key);
        stat.last_zero    = (count_reg == CW'(1));
    end

    always_comb begin
        rd_addr      = '0;
        wr_addr      = pos_reg[AW-1:0];
        wr_data      = hold_reg;
        wr_en        = 1'b0;
        left_next    = left_reg;
        hold_next    = hold_reg;
        top_key_next = top_key_reg;
        top_tag_next = top_tag_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        unique case (cmd)
            bhpq_pkg::CMD_PUSH_START: begin
                hold_next    = {in_key, in_tag};
                pos_next     = {1'b0, count_reg};
                count_next   = count_reg + 1'b1;
                top_key_next = '0;
                top_tag_next = '0;
            end
            bhpq_pkg::CMD_POP_START: begin
                // root was prefetched into rd_data_reg; fetch last entry next
                rd_addr      = AW'(count_reg - 1'b1);
                top_key_next = rd_key;
                top_tag_next = rd_data_reg[TAG_WIDTH-1:0];
                count_next   = count_reg - 1'b1;
                pos_next     = '0;
            end
            bhpq_pkg::CMD_UP_READ: rd_addr = parent[AW-1:0];
            bhpq_pkg::CMD_UP_STEP: begin
                wr_en    = 1'b1;
                wr_data  = rd_data_reg;
                pos_next = parent;
            end
            bhpq_pkg::CMD_DN_READ_L: rd_addr = left_idx[AW-1:0];
            bhpq_pkg::CMD_DN_READ_R: begin
                rd_addr   = right_idx[AW-1:0];
                left_next = rd_data_reg;
            end
            bhpq_pkg::CMD_DN_STEP: begin
                wr_en    = 1'b1;
                wr_data  = pick_right ? rd_data_reg : left_reg;
                pos_next = pick_right ? right_idx : left_idx;
            end
            bhpq_pkg::CMD_WRITE_HOLD: wr_en = 1'b1;
            // idle cycles prefetch the root
            default: rd_addr = '0;
        endcase
    end

    // hold takes the last entry from rd_data_reg, flagged by load_last_reg after pop start read
    logic load_last_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
        left_reg    <= left_next;
        hold_reg    <= load_last_reg ? rd_data_reg : hold_next;
        top_key_reg <= top_key_next;
        top_tag_reg <= top_tag_next;
        pos_reg     <= pos_next;
        if (!aresetn) begin
            count_reg     <= '0;
            load_last_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            load_last_reg <= (cmd == bhpq_pkg::CMD_POP_START);
        end
    end

    assign top_key = top_key_reg;
    assign top_tag = top_tag_reg;
    assign count   = count_reg;
endmodule

### rtl/core/bhpq_ctrl.sv
module bhpq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      out_status,
    output logic            clr_top,
    output bhpq_pkg::cmd_t  cmd,
    input  bhpq_pkg::stat_t stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_POP_WAIT, S_POP_LOAD, S_UP_READ, S_UP_DEC,
        S_DN_L, S_DN_R, S_DN_DEC, S_WRITE, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic clr_reg, clr_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign out_status = status_reg;
    assign clr_top    = clr_reg;

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        clr_next    = clr_reg;
        cmd         = bhpq_pkg::CMD_NONE;
        unique case (state_reg)
            S_IDLE: if (in_valid) begin
                status_next = bhpq_pkg::ST_DONE;
                clr_next    = 1'b0;
                if (!in_pop) begin
                    if (stat.full) begin
                        status_next = bhpq_pkg::ST_FULL;
                        clr_next    = 1'b1;
                        state_next  = S_OUT;
                    end else begin
                        cmd        = bhpq_pkg::CMD_PUSH_START;
                        state_next = S_UP_READ;
                    end
                end else if (stat.empty) begin
                    status_next = bhpq_pkg::ST_EMPTY;
                    clr_next    = 1'b1;
                    state_next  = S_OUT;
                end else begin
                    // the idle read fetches the root
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                // root now registered
                cmd        = bhpq_pkg::CMD_POP_START;
                state_next = stat.last_zero ? S_OUT : S_POP_LOAD;
            end
            S_POP_LOAD: state_next = S_DN_L;
            S_UP_READ: begin
                if (stat.at_root) state_next = S_WRITE;
                else begin
                    cmd        = bhpq_pkg::CMD_UP_READ;
                    state_next = S_UP_DEC;
                end
            end
            S_UP_DEC: begin
                if (stat.up_move) begin
                    cmd        = bhpq_pkg::CMD_UP_STEP;
                    state_next = S_UP_READ;
                end else begin
                    cmd        = bhpq_pkg::CMD_WRITE_HOLD;
                    state_next = S_OUT;
                end
            end
            S_DN_L: begin
                if (!stat.dn_has_left) state_next = S_WRITE;
                else begin
                    cmd        = bhpq_pkg::CMD_DN_READ_L;
                    state_next = S_DN_R;
                end
            end
            S_DN_R: begin
                cmd        = bhpq_pkg::CMD_DN_READ_R;
                state_next = S_DN_DEC;
            end
            S_DN_DEC: begin
                if (stat.dn_move) begin
                    cmd        = bhpq_pkg::CMD_DN_STEP;
                    state_next = S_DN_L;
                end else begin
                    cmd        = bhpq_pkg::CMD_WRITE_HOLD;
                    state_next = S_OUT;
                end
            end
            S_WRITE: begin
                cmd        = bhpq_pkg::CMD_WRITE_HOLD;
                state_next = S_OUT;
            end
            S_OUT: if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= bhpq_pkg::ST_DONE;
            clr_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            clr_reg    <= clr_next;
        end
    end
endmodule
